[rtl/core/lipr_pkg.sv]
`default_nettype none

package lipr_pkg;

	// Frame geometry limits and the counter widths that follow from them.
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int COL_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_W      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

	// Register and sample widths.
	localparam int SIZE_W  = 11;
	localparam int SEL_W   = 3;
	localparam int CH_W    = 8;
	localparam int NUM_CH  = 3;
	localparam int PIX_W   = NUM_CH * CH_W;
	localparam int RES_W   = 10;
	localparam int CALC_W  = CH_W + 3;

	// Width used to compare a position against a configured size.
	localparam int CNT_W = (COL_W > ROW_W) ? COL_W : ROW_W;
	localparam int CMP_W = ((CNT_W > SIZE_W) ? CNT_W : SIZE_W) + 1;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_PRED_SEL   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IMG_HEIGHT = 2'd2;

	// Predictor selector codes.
	localparam logic [SEL_W-1:0] PRED_ZERO       = 3'd0;
	localparam logic [SEL_W-1:0] PRED_LEFT       = 3'd1;
	localparam logic [SEL_W-1:0] PRED_ABOVE      = 3'd2;
	localparam logic [SEL_W-1:0] PRED_DIAG       = 3'd3;
	localparam logic [SEL_W-1:0] PRED_PLANE      = 3'd4;
	localparam logic [SEL_W-1:0] PRED_LEFT_HALF  = 3'd5;
	localparam logic [SEL_W-1:0] PRED_ABOVE_HALF = 3'd6;
	localparam logic [SEL_W-1:0] PRED_AVG        = 3'd7;

	// Register reset values.
	localparam logic [SEL_W-1:0]  RESET_SEL    = PRED_LEFT;
	localparam logic [SIZE_W-1:0] RESET_WIDTH  = SIZE_W'(1024);
	localparam logic [SIZE_W-1:0] RESET_HEIGHT = SIZE_W'(1024);

	// How a pixel is predicted, set by its place in the frame.
	typedef enum logic [1:0] {
		MODE_RAW,
		MODE_LEFT,
		MODE_ABOVE,
		MODE_PRED
	} mode_t;

	// Position information handed from the scan tracker to the lanes.
	typedef struct packed {
		mode_t mode;
		logic  row_end;
		logic  frame_end;
	} pos_t;

endpackage

`default_nettype wire

[rtl/core/lipr_pix_if.sv]
`default_nettype none

interface lipr_pix_if;
	logic                      valid;
	logic                      ready;
	logic [lipr_pkg::CH_W-1:0] red_sample;
	logic [lipr_pkg::CH_W-1:0] green_sample;
	logic [lipr_pkg::CH_W-1:0] blue_sample;

	modport source (output valid, output red_sample, output green_sample,
		output blue_sample, input ready);
	modport sink (input valid, input red_sample, input green_sample,
		input blue_sample, output ready);
endinterface

`default_nettype wire

[rtl/core/lipr_res_if.sv]
`default_nettype none

interface lipr_res_if;
	logic                              valid;
	logic                              ready;
	logic signed [lipr_pkg::RES_W-1:0] red_residual;
	logic signed [lipr_pkg::RES_W-1:0] green_residual;
	logic signed [lipr_pkg::RES_W-1:0] blue_residual;
	logic                              row_end;
	logic                              frame_end;

	modport source (output valid, output red_residual, output green_residual,
		output blue_residual, output row_end, output frame_end, input ready);
	modport sink (input valid, input red_residual, input green_residual,
		input blue_residual, input row_end, input frame_end, output ready);
endinterface

`default_nettype wire

[rtl/core/lipr_lane.sv]
`default_nettype none

module lipr_lane (
	input  var logic [lipr_pkg::CH_W-1:0]         x,
	input  var logic [lipr_pkg::CH_W-1:0]         a,
	input  var logic [lipr_pkg::CH_W-1:0]         b,
	input  var logic [lipr_pkg::CH_W-1:0]         c,
	input  var logic [lipr_pkg::SEL_W-1:0]        sel,
	input  var lipr_pkg::mode_t                   mode,
	output logic signed [lipr_pkg::RES_W-1:0]     resid
);

	logic signed [lipr_pkg::CALC_W-1:0] sx, sa, sb, sc;
	logic signed [lipr_pkg::CALC_W-1:0] d_bc, d_ac, h_bc, h_ac, s_ab;
	logic signed [lipr_pkg::CALC_W-1:0] pred, diff;

	// Widen the samples; halves of differences round toward zero.
	always_comb begin
		sx   = $signed({{(lipr_pkg::CALC_W-lipr_pkg::CH_W){1'b0}}, x});
		sa   = $signed({{(lipr_pkg::CALC_W-lipr_pkg::CH_W){1'b0}}, a});
		sb   = $signed({{(lipr_pkg::CALC_W-lipr_pkg::CH_W){1'b0}}, b});
		sc   = $signed({{(lipr_pkg::CALC_W-lipr_pkg::CH_W){1'b0}}, c});
		d_bc = sb - sc;
		d_ac = sa - sc;
		h_bc = (d_bc + $signed({{(lipr_pkg::CALC_W-1){1'b0}},
			d_bc[lipr_pkg::CALC_W-1]})) >>> 1;
		h_ac = (d_ac + $signed({{(lipr_pkg::CALC_W-1){1'b0}},
			d_ac[lipr_pkg::CALC_W-1]})) >>> 1;
		s_ab = sa + sb;
	end

	// Interior predictor chosen by the selector register.
	always_comb begin
		case (sel)
			lipr_pkg::PRED_ZERO:       pred = '0;
			lipr_pkg::PRED_LEFT:       pred = sa;
			lipr_pkg::PRED_ABOVE:      pred = sb;
			lipr_pkg::PRED_DIAG:       pred = sc;
			lipr_pkg::PRED_PLANE:      pred = sa + sb - sc;
			lipr_pkg::PRED_LEFT_HALF:  pred = sa + h_bc;
			lipr_pkg::PRED_ABOVE_HALF: pred = sb + h_ac;
			lipr_pkg::PRED_AVG:        pred = s_ab >>> 1;
			default:                   pred = '0;
		endcase
	end

	// Edge pixels use a fixed neighbor; the first pixel goes out raw.
	always_comb begin
		case (mode)
			lipr_pkg::MODE_RAW:   diff = sx;
			lipr_pkg::MODE_LEFT:  diff = sa - sx;
			lipr_pkg::MODE_ABOVE: diff = sb - sx;
			default:              diff = pred - sx;
		endcase
	end

	assign resid = $signed(diff[lipr_pkg::RES_W-1:0]);

endmodule

`default_nettype wire

[rtl/core/lipr_scan.sv]
`default_nettype none

module lipr_scan (
	input  var logic                          clk,
	input  var logic                          arst_n,
	input  var logic                          acc,
	input  var logic [lipr_pkg::PIX_W-1:0]    pix_d,
	input  var logic [lipr_pkg::SIZE_W-1:0]   width_cfg,
	input  var logic [lipr_pkg::SIZE_W-1:0]   height_cfg,
	output lipr_pkg::pos_t                    pos_s1,
	output logic [lipr_pkg::PIX_W-1:0]        above_s1
);

	logic [lipr_pkg::PIX_W-1:0] line_mem [lipr_pkg::MAX_WIDTH];
	logic [lipr_pkg::COL_W-1:0] col_q;
	logic [lipr_pkg::ROW_W-1:0] row_q;
	logic [lipr_pkg::CMP_W-1:0] w_eff, h_eff, col_nxt, row_nxt;
	lipr_pkg::pos_t             pos_d;

	// Clamp the configured sizes to the supported range.
	always_comb begin
		w_eff = lipr_pkg::CMP_W'(width_cfg);
		if (w_eff == '0) begin
			w_eff = lipr_pkg::CMP_W'(1);
		end else if (w_eff > lipr_pkg::CMP_W'(lipr_pkg::MAX_WIDTH)) begin
			w_eff = lipr_pkg::CMP_W'(lipr_pkg::MAX_WIDTH);
		end
		h_eff = lipr_pkg::CMP_W'(height_cfg);
		if (h_eff == '0) begin
			h_eff = lipr_pkg::CMP_W'(1);
		end else if (h_eff > lipr_pkg::CMP_W'(lipr_pkg::MAX_HEIGHT)) begin
			h_eff = lipr_pkg::CMP_W'(lipr_pkg::MAX_HEIGHT);
		end
	end

	// Row and frame ends, and the prediction mode of the current position.
	always_comb begin
		col_nxt         = lipr_pkg::CMP_W'(col_q) + lipr_pkg::CMP_W'(1);
		row_nxt         = lipr_pkg::CMP_W'(row_q) + lipr_pkg::CMP_W'(1);
		pos_d.row_end   = (col_nxt >= w_eff);
		pos_d.frame_end = pos_d.row_end && (row_nxt >= h_eff);
		if (row_q == '0 && col_q == '0) begin
			pos_d.mode = lipr_pkg::MODE_RAW;
		end else if (row_q == '0) begin
			pos_d.mode = lipr_pkg::MODE_LEFT;
		end else if (col_q == '0) begin
			pos_d.mode = lipr_pkg::MODE_ABOVE;
		end else begin
			pos_d.mode = lipr_pkg::MODE_PRED;
		end
	end

	// Line buffer: read the pixel above before it is replaced by this one.
	always_ff @(posedge clk) begin
		if (acc) begin
			above_s1       <= line_mem[col_q];
			line_mem[col_q] <= pix_d;
			pos_s1         <= pos_d;
		end
	end

	// Raster position counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (pos_d.row_end) begin
				col_q <= '0;
				if (pos_d.frame_end) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + lipr_pkg::ROW_W'(1);
				end
			end else begin
				col_q <= col_q + lipr_pkg::COL_W'(1);
			end
		end
	end

	a_col_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		acc && pos_d.row_end |=> col_q == '0)
		else $error("column did not wrap at row end");

	a_col_step: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !pos_d.row_end |=> col_q == $past(col_q) + lipr_pkg::COL_W'(1))
		else $error("column did not advance");

	a_row_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		acc && pos_d.frame_end |=> row_q == '0 && col_q == '0)
		else $error("position did not wrap at frame end");

endmodule

`default_nettype wire

[rtl/core/lossless_image_predictive_residual_core.sv]
// Lossless predictive residual coder for RGB pixels in raster order.
// Channel pix carries one pixel word (red, green, blue samples) per
// valid/ready handshake; channel res returns one word per pixel with the
// three signed residuals (prediction minus sample) and row/frame end flags.
// The first pixel of a frame goes out raw; row 0 predicts from the left,
// column 0 from above, interior pixels with the selected predictor.
// Configuration: cfg_we writes cfg_wdata into register cfg_idx
// (0 predictor select, 1 image width, 2 image height); write only when idle.
// Throughput: one pixel per clock while res takes words, set by the
// single-port line buffer that is read and written once per pixel.
// The line buffer is read and stage 1 registered at the accepting edge;
// the lane results are registered into the output word as stage 1 advances.
// Reset clears the position counters and pipeline valids and loads the
// register defaults; the line buffer is not cleared and needs no sweep.
// When res stalls, the output register holds its word and the pipeline
// keeps taking pixels until both of its stages are full.
`default_nettype none

module lossless_image_predictive_residual_core (
	input  var logic                              clk,
	input  var logic                              arst_n,
	lipr_pix_if.sink                              pix,
	lipr_res_if.source                            res,
	input  var logic                              cfg_we,
	input  var logic [lipr_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  var logic [lipr_pkg::SIZE_W-1:0]       cfg_wdata
);

	logic [lipr_pkg::SEL_W-1:0]  sel_q;
	logic [lipr_pkg::SIZE_W-1:0] width_q, height_q;

	logic                        acc, adv_s1;
	logic                        valid_s1, valid_s2;
	logic [lipr_pkg::PIX_W-1:0]  pix_d, x_s1, a_s1, c_s1, above_s1;
	lipr_pkg::pos_t              pos_s1;

	logic signed [lipr_pkg::RES_W-1:0] resid [lipr_pkg::NUM_CH];
	logic signed [lipr_pkg::RES_W-1:0] red_s2, green_s2, blue_s2;
	logic                              row_end_s2, frame_end_s2;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q    <= lipr_pkg::RESET_SEL;
			width_q  <= lipr_pkg::RESET_WIDTH;
			height_q <= lipr_pkg::RESET_HEIGHT;
		end else if (cfg_we) begin
			case (cfg_idx)
				lipr_pkg::CFG_PRED_SEL:   sel_q    <= cfg_wdata[lipr_pkg::SEL_W-1:0];
				lipr_pkg::CFG_IMG_WIDTH:  width_q  <= cfg_wdata;
				lipr_pkg::CFG_IMG_HEIGHT: height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Handshake: stage 1 takes a word when empty or moving on.
	assign adv_s1    = !valid_s2 || res.ready;
	assign pix.ready = !valid_s1 || adv_s1;
	assign acc       = pix.valid && pix.ready;
	assign pix_d     = {pix.red_sample, pix.green_sample, pix.blue_sample};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (pix.ready) begin
				valid_s1 <= pix.valid;
			end
			if (adv_s1) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Position tracking and line buffer.
	lipr_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.acc        (acc),
		.pix_d      (pix_d),
		.width_cfg  (width_q),
		.height_cfg (height_q),
		.pos_s1     (pos_s1),
		.above_s1   (above_s1)
	);

	// Stage 1 neighbors: the left pixel is the previous word, the upper-left
	// pixel is the previous word's pixel above.
	always_ff @(posedge clk) begin
		if (acc) begin
			x_s1 <= pix_d;
			a_s1 <= x_s1;
			c_s1 <= above_s1;
		end
	end

	// One predictor lane per color channel, red in the top byte.
	for (genvar k = 0; k < lipr_pkg::NUM_CH; k++) begin : g_lane
		localparam int HI = lipr_pkg::PIX_W - 1 - lipr_pkg::CH_W * k;
		lipr_lane u_lane (
			.x     (x_s1[HI -: lipr_pkg::CH_W]),
			.a     (a_s1[HI -: lipr_pkg::CH_W]),
			.b     (above_s1[HI -: lipr_pkg::CH_W]),
			.c     (c_s1[HI -: lipr_pkg::CH_W]),
			.sel   (sel_q),
			.mode  (pos_s1.mode),
			.resid (resid[k])
		);
	end

	// Merge the lane results with the position flags into the output word.
	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			red_s2       <= resid[0];
			green_s2     <= resid[1];
			blue_s2      <= resid[2];
			row_end_s2   <= pos_s1.row_end;
			frame_end_s2 <= pos_s1.frame_end;
		end
	end

	assign res.valid          = valid_s2;
	assign res.red_residual   = red_s2;
	assign res.green_residual = green_s2;
	assign res.blue_residual  = blue_s2;
	assign res.row_end        = row_end_s2;
	assign res.frame_end      = frame_end_s2;

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> valid_s1)
		else $error("accepted word did not enter stage 1");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!pix.ready |-> valid_s1 && valid_s2)
		else $error("input stalled while the pipeline had room");

	a_frame_row: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.frame_end |-> res.row_end)
		else $error("frame end without row end");

endmodule

`default_nettype wire

[tb/lossless_image_predictive_residual_core_tb.sv]
`default_nettype none

module lossless_image_predictive_residual_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 550;
	localparam int HOLD_CYCLES  = 64;
	localparam int DRAIN_CYCLES = 16;
	localparam int LIMIT_CYCLES = 400000;
	localparam int MAX_REPORTS  = 40;

	// Index past the end of the register list; writes to it must be ignored.
	localparam logic [lipr_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef struct packed {
		logic [lipr_pkg::CH_W-1:0] red;
		logic [lipr_pkg::CH_W-1:0] green;
		logic [lipr_pkg::CH_W-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [lipr_pkg::RES_W-1:0] red;
		logic [lipr_pkg::RES_W-1:0] green;
		logic [lipr_pkg::RES_W-1:0] blue;
		logic                       row_end;
		logic                       frame_end;
	} residual_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [lipr_pkg::CFG_IDX_W-1:0] cfg_idx;
	logic [lipr_pkg::SIZE_W-1:0]    cfg_wdata;

	lipr_pix_if pix ();
	lipr_res_if res ();

	lossless_image_predictive_residual_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix       (pix),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	// Stimulus and scoreboard storage.
	pixel_t    pending_pixels[$];
	residual_t expected_residuals[$];
	pixel_t    offer_px;
	bit        pix_accepted;
	int        send_idle_pct;
	int        take_idle_pct;
	int        hold_requests;
	int        holds_served;
	int        hold_left;
	int        error_count;
	int        words_seen;
	int        cycle_count;

	// Shadow of the block: registers, line buffer, neighbors and scan position.
	logic [lipr_pkg::SEL_W-1:0]  pred_sel;
	logic [lipr_pkg::SIZE_W-1:0] img_width;
	logic [lipr_pkg::SIZE_W-1:0] img_height;
	pixel_t                      line_buf [lipr_pkg::MAX_WIDTH];
	pixel_t                      left_px;
	pixel_t                      upleft_px;
	int unsigned                 col_pos;
	int unsigned                 row_pos;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Residual of one channel: prediction minus sample, raw at the first pixel.
	function automatic logic [lipr_pkg::RES_W-1:0] channel_residual(int x, int a, int b,
			int c, bit top_row, bit left_col);
		int p;
		if (top_row && left_col)
			return lipr_pkg::RES_W'(x);
		if (top_row) begin
			p = a;
		end else if (left_col) begin
			p = b;
		end else begin
			case (pred_sel)
				lipr_pkg::PRED_ZERO:       p = 0;
				lipr_pkg::PRED_LEFT:       p = a;
				lipr_pkg::PRED_ABOVE:      p = b;
				lipr_pkg::PRED_DIAG:       p = c;
				lipr_pkg::PRED_PLANE:      p = a + b - c;
				lipr_pkg::PRED_LEFT_HALF:  p = a + (b - c) / 2;
				lipr_pkg::PRED_ABOVE_HALF: p = b + (a - c) / 2;
				lipr_pkg::PRED_AVG:        p = (a + b) / 2;
				default:                   p = 0;
			endcase
		end
		return lipr_pkg::RES_W'(p - x);
	endfunction

	// Work out the result word for an accepted pixel and advance the scan.
	task automatic compute_residual(input pixel_t px);
		int unsigned w;
		int unsigned h;
		int unsigned col;
		pixel_t      above;
		residual_t   rr;
		bit          top_row;
		bit          left_col;
		w = (img_width < 1) ? 1 : (img_width > lipr_pkg::MAX_WIDTH) ?
			lipr_pkg::MAX_WIDTH : img_width;
		h = (img_height < 1) ? 1 : (img_height > lipr_pkg::MAX_HEIGHT) ?
			lipr_pkg::MAX_HEIGHT : img_height;
		col = (col_pos >= lipr_pkg::MAX_WIDTH) ? lipr_pkg::MAX_WIDTH - 1 : col_pos;
		above = line_buf[col];
		top_row = (row_pos == 0);
		left_col = (col == 0);
		rr.red   = channel_residual(px.red, left_px.red, above.red, upleft_px.red,
			top_row, left_col);
		rr.green = channel_residual(px.green, left_px.green, above.green, upleft_px.green,
			top_row, left_col);
		rr.blue  = channel_residual(px.blue, left_px.blue, above.blue, upleft_px.blue,
			top_row, left_col);
		rr.row_end = (col + 1 >= w);
		rr.frame_end = rr.row_end && (row_pos + 1 >= h);
		expected_residuals.push_back(rr);
		line_buf[col] = px;
		upleft_px = above;
		left_px = px;
		if (rr.row_end) begin
			col_pos = 0;
			row_pos = rr.frame_end ? 0 : row_pos + 1;
		end else begin
			col_pos = col + 1;
		end
	endtask

	task automatic apply_config(input logic [lipr_pkg::CFG_IDX_W-1:0] idx,
			input logic [lipr_pkg::SIZE_W-1:0] data);
		case (idx)
			lipr_pkg::CFG_PRED_SEL:   pred_sel = data[lipr_pkg::SEL_W-1:0];
			lipr_pkg::CFG_IMG_WIDTH:  img_width = data;
			lipr_pkg::CFG_IMG_HEIGHT: img_height = data;
			default: ;
		endcase
	endtask

	task automatic report_mismatch(input string what, input int got_v, input int want_v);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("mismatch at word %0d: %s got %0d expected %0d",
				words_seen, what, got_v, want_v);
	endtask

	// Compare a result word with the oldest expected one, field by field.
	task automatic check_residual(input residual_t got);
		residual_t want;
		if (expected_residuals.size() == 0) begin
			report_mismatch("word with nothing expected", 0, 0);
			return;
		end
		want = expected_residuals.pop_front();
		if (got.red !== want.red)
			report_mismatch("red_residual", $signed(got.red), $signed(want.red));
		if (got.green !== want.green)
			report_mismatch("green_residual", $signed(got.green), $signed(want.green));
		if (got.blue !== want.blue)
			report_mismatch("blue_residual", $signed(got.blue), $signed(want.blue));
		if (got.row_end !== want.row_end)
			report_mismatch("row_end", got.row_end, want.row_end);
		if (got.frame_end !== want.frame_end)
			report_mismatch("frame_end", got.frame_end, want.frame_end);
	endtask

	// Sample both channels and the register port at the rising edge.
	// Pixels are taken before results so a word never beats its own expectation.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				apply_config(cfg_idx, cfg_wdata);
			if (pix.valid && pix.ready) begin
				compute_residual({pix.red_sample, pix.green_sample, pix.blue_sample});
				pix_accepted = 1'b1;
			end
			if (res.valid && res.ready) begin
				check_residual({res.red_residual, res.green_residual, res.blue_residual,
					res.row_end, res.frame_end});
				words_seen++;
			end
		end
	end

	// Pixel driver: offers the next pending word once the current one is taken.
	always @(negedge clk) begin
		if (arst_n && (!pix.valid || pix_accepted)) begin
			if (pending_pixels.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				offer_px = pending_pixels.pop_front();
				pix.valid        <= 1'b1;
				pix.red_sample   <= offer_px.red;
				pix.green_sample <= offer_px.green;
				pix.blue_sample  <= offer_px.blue;
			end else begin
				pix.valid <= 1'b0;
			end
		end
		pix_accepted = 1'b0;
	end

	// Result receiver: random back-pressure, plus long holds on request.
	always @(negedge clk) begin
		if (holds_served != hold_requests) begin
			holds_served++;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			res.ready <= 1'b0;
		end else begin
			res.ready <= ($urandom_range(0, 99) >= take_idle_pct);
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("lossless_image_predictive_residual_core_tb: errors");
			$finish;
		end
	end

	function automatic logic [lipr_pkg::CH_W-1:0] random_sample();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			default: return lipr_pkg::CH_W'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic queue_pixels(input int n);
		for (int i = 0; i < n; i++)
			pending_pixels.push_back({random_sample(), random_sample(), random_sample()});
	endtask

	// Block until every word is sent and every expected result has come back.
	task automatic wait_drained();
		while (pending_pixels.size() != 0 || pix.valid || expected_residuals.size() != 0)
			@(posedge clk);
	endtask

	task automatic program_reg(input logic [lipr_pkg::CFG_IDX_W-1:0] idx,
			input logic [lipr_pkg::SIZE_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Idle mix follows progress through the random part.
	task automatic set_idling(input int done);
		if (done < RANDOM_ITEMS / 3) begin
			send_idle_pct = 27;
			take_idle_pct = 79;
		end else if (done < 2 * RANDOM_ITEMS / 3) begin
			send_idle_pct = 79;
			take_idle_pct = 27;
		end else begin
			send_idle_pct = 0;
			take_idle_pct = 0;
		end
	endtask

	initial begin
		int random_done;
		int phase;
		int n;
		int saved_pct;
		logic [lipr_pkg::SIZE_W-1:0] sz;

		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_idx          = lipr_pkg::CFG_PRED_SEL;
		cfg_wdata        = '0;
		pix.valid        = 1'b0;
		pix.red_sample   = '0;
		pix.green_sample = '0;
		pix.blue_sample  = '0;
		res.ready        = 1'b0;
		pix_accepted     = 1'b0;
		hold_requests    = 0;
		holds_served     = 0;
		hold_left        = 0;
		error_count      = 0;
		words_seen       = 0;
		cycle_count      = 0;
		pred_sel         = lipr_pkg::RESET_SEL;
		img_width        = lipr_pkg::RESET_WIDTH;
		img_height       = lipr_pkg::RESET_HEIGHT;
		left_px          = '0;
		upleft_px        = '0;
		col_pos          = 0;
		row_pos          = 0;
		for (int i = 0; i < lipr_pkg::MAX_WIDTH; i++)
			line_buf[i] = '0;
		random_done = 0;
		set_idling(0);
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Reset settings: raw first pixel, then left prediction along row 0.
		pending_pixels.push_back('{8'd0, 8'd255, 8'd0});
		pending_pixels.push_back('{8'd255, 8'd0, 8'd255});
		pending_pixels.push_back('{8'd0, 8'd0, 8'd0});
		pending_pixels.push_back('{8'd255, 8'd255, 8'd255});
		wait_drained();

		// Shrink the width mid-row: the row ends at the next pixel. The next
		// row then predicts from above, and its second pixel hits both
		// residual extremes with the plane predictor.
		program_reg(lipr_pkg::CFG_IMG_WIDTH, lipr_pkg::SIZE_W'(2));
		program_reg(lipr_pkg::CFG_IMG_HEIGHT, '1);
		program_reg(lipr_pkg::CFG_PRED_SEL, lipr_pkg::SIZE_W'(lipr_pkg::PRED_PLANE));
		pending_pixels.push_back('{8'd128, 8'd1, 8'd254});
		pending_pixels.push_back('{8'd255, 8'd0, 8'd255});
		pending_pixels.push_back('{8'd0, 8'd255, 8'd0});

		// Every predictor on one column-0 and one interior pixel.
		for (int p = lipr_pkg::PRED_ZERO; p <= lipr_pkg::PRED_AVG; p++) begin
			wait_drained();
			program_reg(lipr_pkg::CFG_PRED_SEL, lipr_pkg::SIZE_W'(p));
			queue_pixels(2);
		end

		// A zero height acts as one row, so this row closes the frame.
		wait_drained();
		program_reg(lipr_pkg::CFG_IMG_HEIGHT, '0);
		queue_pixels(2);

		// An oversized width acts as the maximum; one full row also fills
		// the whole line buffer before sizes start to move around.
		wait_drained();
		program_reg(lipr_pkg::CFG_IMG_WIDTH, '1);
		queue_pixels(lipr_pkg::MAX_WIDTH);

		// Random phases: new settings between phases, often mid-frame.
		phase = 0;
		while (random_done < RANDOM_ITEMS) begin
			wait_drained();
			program_reg(lipr_pkg::CFG_PRED_SEL,
				{8'($urandom_range(0, 255)), lipr_pkg::SEL_W'(phase)});
			if ($urandom_range(0, 2) != 0) begin
				case ($urandom_range(0, 19))
					0:       sz = '0;
					1:       sz = lipr_pkg::SIZE_W'(1);
					2:       sz = '1;
					3:       sz = lipr_pkg::SIZE_W'($urandom_range(lipr_pkg::MAX_WIDTH + 1,
						2047));
					4, 5:    sz = lipr_pkg::SIZE_W'($urandom_range(33, 300));
					default: sz = lipr_pkg::SIZE_W'($urandom_range(2, 32));
				endcase
				program_reg(lipr_pkg::CFG_IMG_WIDTH, sz);
			end
			if ($urandom_range(0, 2) != 0) begin
				case ($urandom_range(0, 9))
					0:       sz = '0;
					1:       sz = '1;
					2:       sz = lipr_pkg::SIZE_W'($urandom_range(lipr_pkg::MAX_HEIGHT + 1,
						2047));
					default: sz = lipr_pkg::SIZE_W'($urandom_range(1, 8));
				endcase
				program_reg(lipr_pkg::CFG_IMG_HEIGHT, sz);
			end
			if ($urandom_range(0, 9) == 0)
				program_reg(CFG_UNUSED, lipr_pkg::SIZE_W'($urandom_range(0, 2047)));
			set_idling(random_done);
			n = $urandom_range(20, 150);
			if (phase == 3) begin
				// Long receiver hold while the sender keeps offering words.
				saved_pct = send_idle_pct;
				send_idle_pct = 0;
				hold_requests++;
				queue_pixels(n);
				while (holds_served != hold_requests || hold_left != 0)
					@(posedge clk);
				send_idle_pct = saved_pct;
			end else if (phase == 6) begin
				// Sender pauses mid-phase until the pipeline has emptied.
				queue_pixels(n / 2);
				wait_drained();
				queue_pixels(n - n / 2);
			end else begin
				queue_pixels(n);
			end
			random_done += n;
			phase++;
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("lossless_image_predictive_residual_core_tb: clean");
		else
			$display("lossless_image_predictive_residual_core_tb: errors");
		$finish;
	end

endmodule

`default_nettype wire
